// ----- sv/joystick_average_map_direction_core_macros.svh -----
// ---------------------------------------------------------------------------
// joystick_average_map_direction_core_macros
// Assertion helpers shared by the joystick core.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_AVERAGE_MAP_DIRECTION_CORE_MACROS_SVH
`define JOYSTICK_AVERAGE_MAP_DIRECTION_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define JAMD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define JAMD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/jamd_pkg.sv -----
// ---------------------------------------------------------------------------
// jamd_pkg
// Shared types and constants of the joystick average/map/direction core.
// ---------------------------------------------------------------------------
package jamd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_RADIUS = 2'd2;

  localparam logic [7:0] CENTER_RESET = 8'd128;
  localparam logic [7:0] DZ_RESET     = 8'd50;
  localparam logic [7:0] ADC_MAX      = 8'd255;
  localparam logic [6:0] FULL_SCALE   = 7'd100;

  // dividend width of the mapping divide: 255 * 100 fits in 15 bits
  localparam int NUM_W = 15;
  localparam int DIV_CNT_W = 4;

  localparam logic [2:0] DIR_NEUTRAL = 3'd0;
  localparam logic [2:0] DIR_RIGHT   = 3'd1;
  localparam logic [2:0] DIR_DOWN    = 3'd2;
  localparam logic [2:0] DIR_LEFT    = 3'd3;
  localparam logic [2:0] DIR_UP      = 3'd4;

  typedef struct packed {
    logic [7:0] x_avg;
    logic [7:0] y_avg;
  } avg_pair_t;

  typedef struct packed {
    logic [7:0] x_center;
    logic [7:0] y_center;
    logic [7:0] dz_radius;
  } jamd_cfg_t;

endpackage

// ----- sv/jamd_front.sv -----
// ---------------------------------------------------------------------------
// jamd_front
// Accumulates sample pairs and turns each full batch into a pair of averages.
// ---------------------------------------------------------------------------
module jamd_front #(
  parameter int BATCH_SIZE = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_x_sample,
  input  logic [7:0]          in_y_sample,
  output logic                q_push,
  input  logic                q_full,
  output jamd_pkg::avg_pair_t q_data
);
  import jamd_pkg::*;

  localparam int CNT_W   = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int ACC_W   = 8 + CNT_W;
  localparam int RECIP_W = ACC_W + 1;
  localparam int PROD_W  = ACC_W + RECIP_W;
  // floor(2^ACC_W / BATCH_SIZE): estimate is exact or one low
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << ACC_W) / BATCH_SIZE);
  localparam logic [CNT_W-1:0]   LAST  = CNT_W'(BATCH_SIZE - 1);
  localparam logic [ACC_W-1:0]   DIVC  = ACC_W'(BATCH_SIZE);

  localparam logic [1:0] F_ACC = 2'd0;
  localparam logic [1:0] F_EST = 2'd1;
  localparam logic [1:0] F_FIX = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [ACC_W-1:0] sum_x_r, sum_y_r, sum_x_add, sum_y_add;
  logic [7:0]       qx_r, qy_r;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [ACC_W-1:0] rem_x, rem_y;
  logic             accept, batch_done;

  assign in_full    = (state_r != F_ACC);
  assign accept     = in_push && !in_full;
  assign batch_done = accept && (cnt_r == LAST);
  assign sum_x_add  = acc_x_r + ACC_W'(in_x_sample);
  assign sum_y_add  = acc_y_r + ACC_W'(in_y_sample);

  assign prod_x = PROD_W'(sum_x_r) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(sum_y_r) * PROD_W'(RECIP);

  // remainder check lifts a low estimate by one
  assign rem_x = sum_x_r - ACC_W'(qx_r) * DIVC;
  assign rem_y = sum_y_r - ACC_W'(qy_r) * DIVC;
  assign q_data.x_avg = (rem_x >= DIVC) ? qx_r + 8'd1 : qx_r;
  assign q_data.y_avg = (rem_y >= DIVC) ? qy_r + 8'd1 : qy_r;
  assign q_push = (state_r == F_FIX) && !q_full;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    unique case (state_r)
      F_ACC: begin
        if (batch_done) begin
          cnt_nxt   = '0;
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          state_nxt = F_EST;
        end else if (accept) begin
          cnt_nxt   = cnt_r + 1'b1;
          acc_x_nxt = sum_x_add;
          acc_y_nxt = sum_y_add;
        end
      end
      F_EST: state_nxt = F_FIX;
      F_FIX: begin
        if (!q_full) begin
          state_nxt = F_ACC;
        end
      end
      default: state_nxt = F_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACC;
      cnt_r   <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_done) begin
      sum_x_r <= sum_x_add;
      sum_y_r <= sum_y_add;
    end
    if (state_r == F_EST) begin
      qx_r <= prod_x[ACC_W+7:ACC_W];
      qy_r <= prod_y[ACC_W+7:ACC_W];
    end
  end

endmodule

// ----- sv/jamd_fifo.sv -----
// ---------------------------------------------------------------------------
// jamd_fifo
// Two-entry queue of average pairs between the front and back ends.
// ---------------------------------------------------------------------------
module jamd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jamd_pkg::avg_pair_t wdata,
  output logic                full,
  input  logic                pop,
  output jamd_pkg::avg_pair_t rdata,
  output logic                empty
);
  import jamd_pkg::*;

  avg_pair_t  slot0_r, slot1_r;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = rd_ptr_r ? slot1_r : slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_ptr_r) begin
      slot0_r <= wdata;
    end
    if (do_push && wr_ptr_r) begin
      slot1_r <= wdata;
    end
  end

endmodule

// ----- sv/jamd_div.sv -----
// ---------------------------------------------------------------------------
// jamd_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module jamd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [jamd_pkg::NUM_W-1:0]   num,
  input  logic [7:0]                   den,
  output logic                         done,
  output logic [7:0]                   quo
);
  import jamd_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(NUM_W - 1);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [7:0]           rem_r, den_r;
  logic [NUM_W-1:0]     quo_r;
  logic [8:0]           trial, diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

// ----- sv/jamd_back.sv -----
// ---------------------------------------------------------------------------
// jamd_back
// Maps averages to -100..100, classifies direction, holds the result word.
// ---------------------------------------------------------------------------
`include "joystick_average_map_direction_core_macros.svh"

module jamd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jamd_pkg::jamd_cfg_t cfg,
  input  logic                q_empty,
  input  jamd_pkg::avg_pair_t q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_x_position,
  output logic [7:0]          out_y_position,
  output logic [2:0]          out_direction
);
  import jamd_pkg::*;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [NUM_W-1:0] num;
    logic [7:0]       den;
  } axis_setup_t;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_SQ   = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  function automatic axis_setup_t axis_setup(input logic [7:0] avg, input logic [7:0] ctr);
    axis_setup_t s;
    logic [7:0]  diff;
    s.neg  = (avg <= ctr);
    diff   = s.neg ? ctr - avg : avg - ctr;
    s.zero = s.neg && (ctr == 8'd0);
    s.num  = NUM_W'(diff) * NUM_W'(FULL_SCALE);
    s.den  = s.neg ? ctr : ADC_MAX - ctr;
    return s;
  endfunction

  logic [1:0]        state_r, state_nxt;
  axis_setup_t       sx, sy;
  logic              negx_r, zerox_r, negy_r, zeroy_r;
  logic              x_done, y_done, start;
  logic [7:0]        x_quo, y_quo, magx, magy;
  logic signed [7:0] xp_r, yp_r;
  logic signed [15:0] xsq_full, ysq_full;
  logic [14:0]       xsq_r, ysq_r;
  logic [15:0]       rsq_r;
  logic [16:0]       sq_sum;
  logic signed [8:0] sum_xy;
  logic [2:0]        dir;
  logic              out_valid_r, out_valid_nxt, out_load;
  logic [7:0]        out_x_r, out_y_r;
  logic [2:0]        out_dir_r;
  logic              pos_ok;

  assign sx    = axis_setup(q_data.x_avg, cfg.x_center);
  assign sy    = axis_setup(q_data.y_avg, cfg.y_center);
  assign start = (state_r == B_IDLE) && !q_empty;
  assign q_pop = start;

  jamd_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (sx.num),
    .den   (sx.den),
    .done  (x_done),
    .quo   (x_quo)
  );

  jamd_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (sy.num),
    .den   (sy.den),
    .done  (y_done),
    .quo   (y_quo)
  );

  // zero center with zero average: 0/0 repaired to 0
  assign magx = zerox_r ? 8'd0 : x_quo;
  assign magy = zeroy_r ? 8'd0 : y_quo;

  assign xsq_full = xp_r * xp_r;
  assign ysq_full = yp_r * yp_r;
  assign sq_sum   = 17'(xsq_r) + 17'(ysq_r);
  assign sum_xy   = 9'(xp_r) + 9'(yp_r);

  always_comb begin
    if (sq_sum < 17'(rsq_r)) begin
      dir = DIR_NEUTRAL;
    end else if (xp_r > yp_r) begin
      dir = (sum_xy > 9'sd0) ? DIR_RIGHT : DIR_DOWN;
    end else begin
      dir = (sum_xy < 9'sd0) ? DIR_LEFT : DIR_UP;
    end
  end

  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (x_done) begin
          state_nxt = B_SQ;
        end
      end
      B_SQ:  state_nxt = B_OUT;
      B_OUT: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      negx_r  <= sx.neg;
      zerox_r <= sx.zero;
      negy_r  <= sy.neg;
      zeroy_r <= sy.zero;
    end
    if ((state_r == B_DIV) && x_done) begin
      xp_r <= negx_r ? -magx : magx;
      yp_r <= negy_r ? -magy : magy;
    end
    if (state_r == B_SQ) begin
      xsq_r <= xsq_full[14:0];
      ysq_r <= ysq_full[14:0];
      rsq_r <= 16'(cfg.dz_radius) * 16'(cfg.dz_radius);
    end
    if (out_load) begin
      out_x_r   <= xp_r;
      out_y_r   <= yp_r;
      out_dir_r <= dir;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_x_position = out_x_r;
  assign out_y_position = out_y_r;
  assign out_direction  = out_dir_r;

  assign pos_ok = ($signed(out_x_r) >= -8'sd100) && ($signed(out_x_r) <= 8'sd100) &&
                  ($signed(out_y_r) >= -8'sd100) && ($signed(out_y_r) <= 8'sd100);

  `JAMD_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, !q_empty, "pop of empty queue")
  `JAMD_ASSERT_IMP(a_div_lockstep, clk, rst_n, 1'b1, x_done == y_done, "dividers out of step")
  `JAMD_ASSERT_IMP(a_done_in_div, clk, rst_n, x_done, state_r == B_DIV, "divide done outside wait")
  `JAMD_ASSERT_NXT(a_pos_range, clk, rst_n, out_load, pos_ok, "position out of range")

endmodule

// ----- sv/joystick_average_map_direction_core.sv -----
// ---------------------------------------------------------------------------
// joystick_average_map_direction_core
// Averages joystick X/Y samples per batch, maps them and classifies direction.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (in_x_sample, in_y_sample) are pushed with in_push while
//   in_full is low. Every BATCH_SIZE-th word closes a batch and yields one
//   result word; the other words yield none.
//   Result words (position pair and direction) wait on the out_ ports while
//   out_empty is low and leave with out_pop.
//   Config: cfg_we with cfg_index 0 x center, 1 y center, 2 dead-zone
//   radius; index 3 is ignored. Write only while the core is idle.
// Timing:
//   Words that do not close a batch are taken while in_full is low. A batch-closing word
//   holds in_full high while the averages are formed (multiply by
//   reciprocal, then a remainder fix) and until the pair enters the queue.
//   The mapping divides form the quotients one bit per step; with the result
//   register free, the result word is loaded after the divide and square states.
//   A two-word queue lets a new batch gather while the previous one is mapped.
// Reset: clears accumulators, batch count, queue and result; centers go
//   to 128, radius to 50. A stalled result simply holds; the back end
//   waits, then the queue fills, then in_full rises.
// ---------------------------------------------------------------------------
module joystick_average_map_direction_core #(
  parameter int BATCH_SIZE = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [7:0]                           in_x_sample,
  input  logic [7:0]                           in_y_sample,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [7:0]                           out_x_position,
  output logic [7:0]                           out_y_position,
  output logic [2:0]                           out_direction,
  input  logic                                 cfg_we,
  input  logic [jamd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data
);
  import jamd_pkg::*;

  jamd_cfg_t cfg_r;
  avg_pair_t push_data, pop_data;
  logic      q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_center  <= CENTER_RESET;
      cfg_r.y_center  <= CENTER_RESET;
      cfg_r.dz_radius <= DZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_CENTER:  cfg_r.x_center  <= cfg_data;
        CFG_Y_CENTER:  cfg_r.y_center  <= cfg_data;
        CFG_DZ_RADIUS: cfg_r.dz_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  jamd_front #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_x_sample (in_x_sample),
    .in_y_sample (in_y_sample),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_data      (push_data)
  );

  jamd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_data),
    .empty (q_empty)
  );

  jamd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_x_position (out_x_position),
    .out_y_position (out_y_position),
    .out_direction  (out_direction)
  );

endmodule

// ----- test/joystick_average_map_direction_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joystick_average_map_direction_core_tb
// Pushes batches of X/Y sample words through the core under several center
// and dead-zone settings. A tracker predicts each batch's position pair and
// direction and checks every popped result word in order.
// ---------------------------------------------------------------------------
module joystick_average_map_direction_core_tb;
  import jamd_pkg::*;

  localparam int BATCH = 5;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 48;
  localparam logic [7:0] DZ_FULL = 8'd141;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped, writes dropped

  typedef struct packed {
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [2:0] dir;
  } joy_move_t;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_LONG_STALL} pop_mode_t;

  class joystick_move_tracker;
    logic [7:0] x_ctr, y_ctr, dz;
    logic [13:0] x_sum, y_sum;
    int count;
    int errors;
    joy_move_t expected_moves[$];

    function new();
      x_ctr = CENTER_RESET;
      y_ctr = CENTER_RESET;
      dz = DZ_RESET;
      x_sum = '0;
      y_sum = '0;
      count = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_X_CENTER: x_ctr = val;
        CFG_Y_CENTER: y_ctr = val;
        CFG_DZ_RADIUS: dz = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] map_to_position(logic [7:0] avg, logic [7:0] ctr);
      int mag;
      if (avg <= ctr) begin
        if (ctr == 0) return 8'd0;  // zero center, zero average
        mag = (int'(ctr) - int'(avg)) * int'(FULL_SCALE) / int'(ctr);
        return 8'(-mag);
      end
      mag = (int'(avg) - int'(ctr)) * int'(FULL_SCALE) / (int'(ADC_MAX) - int'(ctr));
      return 8'(mag);
    endfunction

    function logic [2:0] classify_direction(logic signed [7:0] xp, logic signed [7:0] yp);
      int x, y, r;
      x = xp;
      y = yp;
      r = dz;
      if (x * x + y * y < r * r) return DIR_NEUTRAL;
      if (x > y) return (-x < y) ? DIR_RIGHT : DIR_DOWN;
      return (-x > y) ? DIR_LEFT : DIR_UP;
    endfunction

    function void sample_accepted(logic [7:0] xs, logic [7:0] ys);
      joy_move_t m;
      logic [7:0] xa, ya;
      x_sum = x_sum + xs;
      y_sum = y_sum + ys;
      count++;
      if (count < BATCH) return;
      xa = 8'(x_sum / BATCH);
      ya = 8'(y_sum / BATCH);
      x_sum = '0;
      y_sum = '0;
      count = 0;
      m.x_pos = map_to_position(xa, x_ctr);
      m.y_pos = map_to_position(ya, y_ctr);
      m.dir = classify_direction(m.x_pos, m.y_pos);
      expected_moves.push_back(m);
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task result_popped(logic [7:0] xp, logic [7:0] yp, logic [2:0] dir);
      joy_move_t m;
      if (expected_moves.size() == 0) begin
        report($sformatf("unexpected word x=%0d y=%0d dir=%0d",
                         $signed(xp), $signed(yp), dir));
        return;
      end
      m = expected_moves.pop_front();
      if (xp !== m.x_pos)
        report($sformatf("x_position %0d, want %0d", $signed(xp), $signed(m.x_pos)));
      if (yp !== m.y_pos)
        report($sformatf("y_position %0d, want %0d", $signed(yp), $signed(m.y_pos)));
      if (dir !== m.dir)
        report($sformatf("direction %0d, want %0d", dir, m.dir));
    endtask

    task drain_check();
      joy_move_t m;
      while (expected_moves.size() != 0) begin
        m = expected_moves.pop_front();
        report($sformatf("missing word x=%0d y=%0d dir=%0d",
                         $signed(m.x_pos), $signed(m.y_pos), m.dir));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [7:0] in_x_sample;
  logic [7:0] in_y_sample;
  logic out_empty;
  logic out_pop;
  logic [7:0] out_x_position;
  logic [7:0] out_y_position;
  logic [2:0] out_direction;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  joystick_move_tracker tracker;
  int burst_left;
  bit steady;
  int rx_cycle;
  pop_mode_t rx_mode;

  joystick_average_map_direction_core #(
    .BATCH_SIZE(BATCH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_x_sample(in_x_sample),
    .in_y_sample(in_y_sample),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_x_position(out_x_position),
    .out_y_position(out_y_position),
    .out_direction(out_direction),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL joystick_average_map_direction_core");
    $finish;
  end

  task automatic push_word(logic [7:0] xs, logic [7:0] ys);
    @(negedge clk);
    in_push <= 1'b1;
    in_x_sample <= xs;
    in_y_sample <= ys;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.sample_accepted(xs, ys);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_word(logic [7:0] xs, logic [7:0] ys);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady) hold_off($urandom_range(0, 20));
    end
    burst_left--;
    push_word(xs, ys);
  endtask

  function automatic int pick_target();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 255 : 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [7:0] near(int t, int j);
    int v;
    v = t + int'($urandom_range(0, 2 * j)) - j;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // mostly tight clusters around a target so all directions show up
  task automatic send_batch();
    int tx, ty, jit;
    if ($urandom_range(0, 99) < 15) begin
      repeat (BATCH) send_word(8'($urandom), 8'($urandom));
    end else begin
      tx = pick_target();
      ty = pick_target();
      jit = $urandom_range(0, 8);
      repeat (BATCH) send_word(near(tx, jit), near(ty, jit));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_register(idx, val);
  endtask

  task automatic configure(logic [7:0] xc, logic [7:0] yc, logic [7:0] r);
    write_reg(CFG_X_CENTER, xc);
    write_reg(CFG_Y_CENTER, yc);
    write_reg(CFG_DZ_RADIUS, r);
    if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the core to go idle before touching config
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = pop_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_COIN: out_pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: out_pop <= (rx_cycle % 5 == 0);
      default: out_pop <= (rx_cycle % 64 >= 50);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      tracker.result_popped(out_x_position, out_y_position, out_direction);
  end

  initial begin
    int dx[4];
    int dy[4];
    int i;
    int p;
    int b;
    tracker = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_x_sample = '0;
    in_y_sample = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_X_CENTER;
    cfg_data = '0;
    rx_cycle = 0;
    rx_mode = POP_ALWAYS;
    burst_left = 0;
    steady = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset config: full left, full up, right, down
    dx = '{0, 255, 255, 128};
    dy = '{0, 255, 128, 0};
    for (i = 0; i < 4; i++) begin
      repeat (BATCH) push_word(8'(dx[i]), 8'(dy[i]));
    end
    // zero centers with zero average, radius past the corner
    settle();
    configure(8'd0, 8'd0, 8'd255);
    repeat (BATCH) push_word(8'd0, 8'd0);

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: configure(ADC_MAX, ADC_MAX, 8'd0);
        1: configure(8'd0, 8'd0, DZ_FULL);
        2: configure(CENTER_RESET, CENTER_RESET, DZ_RESET);
        3: configure(8'd1, 8'd254, 8'd255);
        default: configure(8'($urandom), 8'($urandom),
                           $urandom_range(0, 3) == 0 ? 8'($urandom_range(142, 255))
                                                     : 8'($urandom_range(0, 141)));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (b = 0; b < WORDS_PER_PHASE / BATCH; b++) send_batch();
    end

    settle();
    tracker.drain_check();
    if (tracker.errors == 0)
      $display("PASS joystick_average_map_direction_core");
    else
      $display("FAIL joystick_average_map_direction_core");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/jamd_pkg.sv
sv/jamd_front.sv
sv/jamd_fifo.sv
sv/jamd_div.sv
sv/jamd_back.sv
sv/joystick_average_map_direction_core.sv
test/joystick_average_map_direction_core_tb.sv
